/* src/sac_pkg.sv */
package sac_pkg;

    // Fixed field widths of the access and result words.
    localparam int ADDR_W     = 64;
    localparam int STAMP_W    = 32;
    localparam int OUT_CNT_W  = 32;
    localparam int LFSR_W     = 16;
    localparam int OFF_W      = 4;
    localparam int IBC_W      = 4;
    localparam int WAY_W      = 3;
    localparam int IDX_MAX_W  = (1 << IBC_W) - 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam int DEF_SET_COUNT   = 256;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
    localparam logic [OFF_W-1:0]  OFF_RESET  = 4'd6;
    localparam logic [IBC_W-1:0]  IBC_RESET  = 4'd8;
    localparam logic [WAY_W-1:0]  WAYS_RESET = 3'd4;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_RAND = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 4'd0,
        CFG_INDEX_BITS  = 4'd1,
        CFG_WAYS        = 4'd2,
        CFG_POLICY      = 4'd3
    } cfg_reg_t;

    localparam int NUM_COUNTERS = 6;

    typedef enum logic [2:0] {
        CNT_MISS  = 3'd0,
        CNT_HIT   = 3'd1,
        CNT_RMISS = 3'd2,
        CNT_WMISS = 3'd3,
        CNT_RHIT  = 3'd4,
        CNT_WHIT  = 3'd5
    } cnt_sel_t;

    typedef struct packed {
        logic             lru_start;
        logic             rand_start;
        logic [WAY_W-1:0] ways;
    } victim_req_t;

    typedef struct packed {
        logic             done;
        logic [WAY_W-1:0] way;
    } victim_resp_t;

    typedef struct packed {
        logic bump;
        logic hit;
        logic is_write;
    } cnt_event_t;

    // Right-shifting Fibonacci LFSR with taps 16, 14, 13 and 11.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

/* src/set_assoc_cache_lookup_top.sv */
// Channel  Direction  Handshake          Contents
// s_       in         s_tvalid/s_tready  tdata: address; tuser: cmd (0 read, 1 write)
// m_       out        m_tvalid/m_tready  tdata: hit, way_used, evicted, six counters
// cfg_     in         cfg_valid/cfg_ready register index and write data
//
// For a power-of-two set count the set is read in the accept cycle and compared
// in the next; a hit or a fill is written back and reported once the result word
// is free. Other set counts reduce the index by a reciprocal multiply in ST_RED1
// and read the set in ST_RED2. An eviction adds the victim unit: an LRU age scan
// over the ways in use or an LFSR remainder a nibble at a time. After reset the
// valid bits are cleared set by set with s_tready low; cfg_ready is always high.
// A stalled result word blocks only the write-back of the item behind it.
module set_assoc_cache_lookup_top #(
    parameter int SET_COUNT   = sac_pkg::DEF_SET_COUNT,
    parameter int NUM_WAYS    = sac_pkg::DEF_NUM_WAYS,
    parameter int COUNT_WIDTH = sac_pkg::DEF_COUNT_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tdata: address [63:0]
    input  logic [63:0]                     s_tdata,
    // tuser: cmd [0]
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: hit [0], way_used [2:1], evicted [3], total_misses [35:4],
    // total_hits [67:36], read_misses [99:68], write_misses [131:100],
    // read_hits [163:132], write_hits [195:164], zero fill [199:196]
    output logic [199:0]                    m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import sac_pkg::*;

    localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int ENTRY_W   = ADDR_W + STAMP_W;
    localparam int ROW_W     = NUM_WAYS * ENTRY_W;
    localparam bit SETS_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);
    localparam int RECIP_W   = IDX_MAX_W + 1;
    localparam int RECIP     = (1 << IDX_MAX_W) / SET_COUNT;
    localparam int SETS_CW   = $clog2(SET_COUNT + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RED1   = 6'b000010,
        ST_RED2   = 6'b000100,
        ST_LOOKUP = 6'b001000,
        ST_VICTIM = 6'b010000,
        ST_COMMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [OFF_W-1:0] off_reg;
    logic [IBC_W-1:0] ibc_reg;
    logic [WAY_W-1:0] ways_reg;
    logic             policy_reg;

    // Access held while it is worked on.
    logic                 cmd_reg;
    logic [ADDR_W-1:0]    tag_reg;
    logic [IDX_MAX_W-1:0] idx_raw_reg;
    logic [IDX_MAX_W-1:0] q_reg;
    logic [SET_W-1:0]     set_reg;
    logic [WAY_W-1:0]     victim_way_reg;
    logic [STAMP_W-1:0]   time_reg;

    // Result word.
    logic             m_tvalid_reg;
    logic             out_hit_reg;
    logic [1:0]       out_way_reg;
    logic             out_evict_reg;

    logic                 accept;
    logic                 clr_busy;
    logic [ADDR_W-1:0]    addr_shift;
    logic [IDX_MAX_W-1:0] idx_mask;
    logic [IDX_MAX_W-1:0] idx_in;
    logic [SET_W-1:0]     in_set;
    logic [IDX_MAX_W+RECIP_W-1:0] prod;
    logic [IDX_MAX_W+SETS_CW-1:0] qn;
    logic [IDX_MAX_W:0]   red_rem;
    logic [IDX_MAX_W:0]   red_fix;
    logic [SET_W-1:0]     red_set;

    logic                 rd_en;
    logic [SET_W-1:0]     rd_set;
    logic [NUM_WAYS-1:0]  rd_valid;
    logic [ROW_W-1:0]     rd_entry;
    logic [NUM_WAYS-1:0]  wr_valid;
    logic [ROW_W-1:0]     wr_entry;
    logic [NUM_WAYS*STAMP_W-1:0] stamps;

    logic [WAY_W-1:0]     ways_eff;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic                 fill_any;
    logic [WAY_W-1:0]     fill_way;
    logic [STAMP_W-1:0]   now;
    logic                 out_free;
    logic                 commit;
    logic                 commit_hit;
    logic [WAY_W-1:0]     commit_way;
    logic                 miss_full;

    victim_req_t  vreq;
    victim_resp_t vresp;
    cnt_event_t   cevt;
    logic [NUM_COUNTERS-1:0][COUNT_WIDTH-1:0] counts;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign now       = time_reg + 1'b1;

    // Address split: the set index field is masked to index_bit_count bits.
    assign addr_shift = s_tdata >> off_reg;
    assign idx_mask   = (IDX_MAX_W'(1) << ibc_reg) - 1'b1;
    assign idx_in     = addr_shift[IDX_MAX_W-1:0] & idx_mask;
    assign in_set     = SET_W'(idx_in & IDX_MAX_W'(SET_COUNT - 1));

    // Set counts that are not a power of two: index mod SET_COUNT through a
    // reciprocal multiply, then one correcting subtract.
    assign prod    = idx_raw_reg * RECIP_W'(RECIP);
    assign qn      = q_reg * SETS_CW'(SET_COUNT);
    assign red_rem = {1'b0, idx_raw_reg} - (IDX_MAX_W + 1)'(qn);
    assign red_fix = (red_rem >= (IDX_MAX_W + 1)'(SET_COUNT)) ?
                     red_rem - (IDX_MAX_W + 1)'(SET_COUNT) : red_rem;
    assign red_set = SET_W'(red_fix);

    assign rd_en  = (accept && SETS_POW2) || (state_reg == ST_RED2);
    assign rd_set = (state_reg == ST_RED2) ? red_set : in_set;

    sac_store #(
        .SET_COUNT (SET_COUNT),
        .NUM_WAYS  (NUM_WAYS),
        .SET_W     (SET_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_set   (rd_set),
        .wr_en    (commit),
        .wr_set   (set_reg),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .clr_busy (clr_busy)
    );

    // Zero ways in use means one; more than the hardware has means all of them.
    always_comb begin
        if (ways_reg == '0) begin
            ways_eff = WAY_W'(1);
        end else if (int'(ways_reg) > NUM_WAYS) begin
            ways_eff = WAY_W'(NUM_WAYS);
        end else begin
            ways_eff = ways_reg;
        end
    end

    // Tag compare and free-way search over the ways in use; the lowest way wins.
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        fill_any = 1'b0;
        fill_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w < int'(ways_eff)) begin
                if (rd_valid[w] && (rd_entry[w*ENTRY_W +: ADDR_W] == tag_reg)) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!rd_valid[w]) begin
                    fill_any = 1'b1;
                    fill_way = WAY_W'(w);
                end
            end
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            stamps[w*STAMP_W +: STAMP_W] = rd_entry[w*ENTRY_W + ADDR_W +: STAMP_W];
        end
    end

    assign miss_full  = (state_reg == ST_LOOKUP) && !hit && !fill_any;
    assign commit_hit = (state_reg == ST_LOOKUP) && hit;
    assign commit     = out_free && (((state_reg == ST_LOOKUP) && (hit || fill_any)) ||
                                     (state_reg == ST_COMMIT));
    assign commit_way = (state_reg == ST_COMMIT) ? victim_way_reg :
                        (hit ? hit_way : fill_way);

    // Read-modify-write of the set row: only the chosen way changes.
    always_comb begin
        wr_valid = rd_valid;
        wr_entry = rd_entry;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == int'(commit_way)) begin
                wr_valid[w]                    = 1'b1;
                wr_entry[w*ENTRY_W +: ENTRY_W] = {now, tag_reg};
            end
        end
    end

    assign vreq.lru_start  = miss_full && (policy_reg == POLICY_LRU);
    assign vreq.rand_start = miss_full && (policy_reg == POLICY_RAND);
    assign vreq.ways       = ways_eff;

    sac_victim #(
        .NUM_WAYS (NUM_WAYS)
    ) u_victim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (vreq),
        .now     (now),
        .stamps  (stamps),
        .resp    (vresp)
    );

    assign cevt.bump     = commit;
    assign cevt.hit      = commit_hit;
    assign cevt.is_write = cmd_reg;

    sac_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .aclk    (aclk),
        .aresetn (aresetn),
        .evt     (cevt),
        .counts  (counts)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = SETS_POW2 ? ST_LOOKUP : ST_RED1;
                end
            end
            ST_RED1: begin
                state_next = ST_RED2;
            end
            ST_RED2: begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (miss_full) begin
                    state_next = ST_VICTIM;
                end else if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_VICTIM: begin
                if (vresp.done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            time_reg     <= '0;
            off_reg      <= OFF_RESET;
            ibc_reg      <= IBC_RESET;
            ways_reg     <= WAYS_RESET;
            policy_reg   <= POLICY_LRU;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_tvalid_reg <= 1'b1;
                time_reg     <= now;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: off_reg    <= cfg_data[OFF_W-1:0];
                    CFG_INDEX_BITS:  ibc_reg    <= cfg_data[IBC_W-1:0];
                    CFG_WAYS:        ways_reg   <= cfg_data[WAY_W-1:0];
                    CFG_POLICY:      policy_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= s_tuser[0];
            tag_reg     <= s_tdata >> (5'(off_reg) + 5'(ibc_reg));
            idx_raw_reg <= idx_in;
        end
        if (state_reg == ST_RED1) begin
            q_reg <= prod[IDX_MAX_W +: IDX_MAX_W];
        end
        if (rd_en) begin
            set_reg <= rd_set;
        end
        if (vresp.done) begin
            victim_way_reg <= vresp.way;
        end
        if (commit) begin
            out_hit_reg   <= commit_hit;
            out_way_reg   <= commit_way[1:0];
            out_evict_reg <= (state_reg == ST_COMMIT);
        end
    end

    // The counters change only when a result is loaded, so they sit beside it.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000,
                       OUT_CNT_W'(counts[CNT_WHIT]),
                       OUT_CNT_W'(counts[CNT_RHIT]),
                       OUT_CNT_W'(counts[CNT_WMISS]),
                       OUT_CNT_W'(counts[CNT_RMISS]),
                       OUT_CNT_W'(counts[CNT_HIT]),
                       OUT_CNT_W'(counts[CNT_MISS]),
                       out_evict_reg, out_way_reg, out_hit_reg};

endmodule

/* src/sac_store.sv */
module sac_store #(
    parameter int SET_COUNT = sac_pkg::DEF_SET_COUNT,
    parameter int NUM_WAYS  = sac_pkg::DEF_NUM_WAYS,
    parameter int SET_W     = 8
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   rd_en,
    input  logic [SET_W-1:0]                                       rd_set,
    input  logic                                                   wr_en,
    input  logic [SET_W-1:0]                                       wr_set,
    input  logic [NUM_WAYS-1:0]                                    wr_valid,
    input  logic [NUM_WAYS*(sac_pkg::ADDR_W+sac_pkg::STAMP_W)-1:0] wr_entry,
    output logic [NUM_WAYS-1:0]                                    rd_valid,
    output logic [NUM_WAYS*(sac_pkg::ADDR_W+sac_pkg::STAMP_W)-1:0] rd_entry,
    output logic                                                   clr_busy
);
    import sac_pkg::*;

    localparam int ROW_W = NUM_WAYS * (ADDR_W + STAMP_W);

    logic [NUM_WAYS-1:0] valid_mem [SET_COUNT];
    logic [ROW_W-1:0]    entry_mem [SET_COUNT];

    logic [NUM_WAYS-1:0] rd_valid_reg;
    logic [ROW_W-1:0]    rd_entry_reg;
    logic                clr_busy_reg;
    logic [SET_W-1:0]    clr_addr_reg;

    // After reset the valid bits are swept to zero, one set per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == SET_W'(SET_COUNT - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            valid_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            valid_mem[wr_set] <= wr_valid;
        end
        if (rd_en) begin
            rd_valid_reg <= valid_mem[rd_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_set] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= entry_mem[rd_set];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;
    assign clr_busy = clr_busy_reg;

endmodule

/* src/sac_victim.sv */
module sac_victim #(
    parameter int NUM_WAYS = sac_pkg::DEF_NUM_WAYS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sac_pkg::victim_req_t                   req,
    input  logic [sac_pkg::STAMP_W-1:0]            now,
    input  logic [NUM_WAYS*sac_pkg::STAMP_W-1:0]   stamps,
    output sac_pkg::victim_resp_t                  resp
);
    import sac_pkg::*;

    localparam int RAND_BITS  = 4;
    localparam int RAND_STEPS = LFSR_W / RAND_BITS;
    localparam int STEP_W     = (RAND_STEPS > 1) ? $clog2(RAND_STEPS) : 1;

    logic               lru_busy_reg;
    logic [WAY_W-1:0]   scan_reg;
    logic [STAMP_W-1:0] best_age_reg;
    logic [WAY_W-1:0]   best_way_reg;
    logic [WAY_W-1:0]   ways_reg;

    logic               rand_busy_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [LFSR_W-1:0]  div_reg;
    logic [WAY_W-1:0]   rem_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [STAMP_W-1:0] stamp_sel;
    logic [STAMP_W-1:0] age;
    logic               take;
    logic [WAY_W-1:0]   lru_way;
    logic               lru_last;

    logic [LFSR_W-1:0]  div_v;
    logic [WAY_W-1:0]   rem_v;
    logic [WAY_W:0]     trial;
    logic               rand_last;

    // LRU scan: one way per cycle, oldest age wins, ties keep the lower way.
    always_comb begin
        stamp_sel = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == int'(scan_reg)) begin
                stamp_sel = stamps[w*STAMP_W +: STAMP_W];
            end
        end
        age      = now - stamp_sel;
        take     = (scan_reg == '0) || (age > best_age_reg);
        lru_way  = take ? scan_reg : best_way_reg;
        lru_last = (scan_reg == ways_reg - 1'b1);
    end

    // Restoring remainder of the LFSR value by the way count, a nibble per cycle.
    always_comb begin
        div_v = div_reg;
        rem_v = rem_reg;
        trial = '0;
        for (int i = 0; i < RAND_BITS; i++) begin
            trial = {rem_v, div_v[LFSR_W-1]};
            div_v = {div_v[LFSR_W-2:0], 1'b0};
            if (trial >= {1'b0, ways_reg}) begin
                trial = trial - {1'b0, ways_reg};
            end
            rem_v = trial[WAY_W-1:0];
        end
        rand_last = (step_reg == STEP_W'(RAND_STEPS - 1));
    end

    assign resp.done = (lru_busy_reg && lru_last) || (rand_busy_reg && rand_last);
    assign resp.way  = lru_busy_reg ? lru_way : rem_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lru_busy_reg  <= 1'b0;
            rand_busy_reg <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
        end else begin
            if (req.lru_start) begin
                lru_busy_reg <= 1'b1;
                scan_reg     <= '0;
                ways_reg     <= req.ways;
            end else if (lru_busy_reg) begin
                if (lru_last) begin
                    lru_busy_reg <= 1'b0;
                end
                if (take) begin
                    best_age_reg <= age;
                    best_way_reg <= scan_reg;
                end
                scan_reg <= scan_reg + 1'b1;
            end

            if (req.rand_start) begin
                rand_busy_reg <= 1'b1;
                lfsr_reg      <= lfsr_next(lfsr_reg);
                div_reg       <= lfsr_next(lfsr_reg);
                rem_reg       <= '0;
                step_reg      <= '0;
                ways_reg      <= req.ways;
            end else if (rand_busy_reg) begin
                if (rand_last) begin
                    rand_busy_reg <= 1'b0;
                end
                div_reg  <= div_v;
                rem_reg  <= rem_v;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

endmodule

/* src/sac_counters.sv */
module sac_counters #(
    parameter int COUNT_WIDTH = sac_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  sac_pkg::cnt_event_t                             evt,
    output logic [sac_pkg::NUM_COUNTERS-1:0][COUNT_WIDTH-1:0] counts
);
    import sac_pkg::*;

    logic [NUM_COUNTERS-1:0][COUNT_WIDTH-1:0] cnt_reg;
    logic [NUM_COUNTERS-1:0]                  inc;

    always_comb begin
        inc            = '0;
        inc[CNT_MISS]  = evt.bump && !evt.hit;
        inc[CNT_HIT]   = evt.bump && evt.hit;
        inc[CNT_RMISS] = evt.bump && !evt.hit && !evt.is_write;
        inc[CNT_WMISS] = evt.bump && !evt.hit && evt.is_write;
        inc[CNT_RHIT]  = evt.bump && evt.hit && !evt.is_write;
        inc[CNT_WHIT]  = evt.bump && evt.hit && evt.is_write;
    end

    // Each counter sticks at its all-ones value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                if (inc[k] && (cnt_reg[k] != '1)) begin
                    cnt_reg[k] <= cnt_reg[k] + 1'b1;
                end
            end
        end
    end

    assign counts = cnt_reg;

endmodule
